/* rtl/i2ra_pkg.sv */
package i2ra_pkg;

   localparam int MAX_DIGITS   = 32;
   localparam int VALUE_WIDTH  = 31;
   localparam int RADIX_WIDTH  = 5;
   localparam int CHAR_WIDTH   = 7;
   localparam int DIGIT_WIDTH  = 4;
   localparam int ADDR_WIDTH   = $clog2(MAX_DIGITS);
   localparam int COUNT_WIDTH  = $clog2(MAX_DIGITS + 1);
   localparam int DIV_WIDTH    = 32;
   localparam int CHUNK_BITS   = 8;
   localparam int CHUNKS       = DIV_WIDTH / CHUNK_BITS;
   localparam int CHUNK_CNT_W  = $clog2(CHUNKS);

   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN  = RADIX_WIDTH'(2);
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX  = RADIX_WIDTH'(16);
   localparam logic [CHAR_WIDTH-1:0]  CHAR_ZERO  = CHAR_WIDTH'(48);
   localparam logic [CHAR_WIDTH-1:0]  ALPHA_GAP  = CHAR_WIDTH'(7);
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_NINE = DIGIT_WIDTH'(9);

   typedef logic [2:0] step_type;

   // Program addresses
   localparam step_type STEP_IDLE   = 3'd0;
   localparam step_type STEP_DIVIDE = 3'd1;
   localparam step_type STEP_STORE  = 3'd2;
   localparam step_type STEP_POINT  = 3'd3;
   localparam step_type STEP_EMIT   = 3'd4;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_NO_START,
      COND_CHUNK_MORE,
      COND_MORE_DIGITS,
      COND_PTR_NONZERO
   } cond_type;

   typedef struct packed {
      logic     busy;
      logic     load;
      logic     divide;
      logic     store;
      logic     set_ptr;
      logic     emit;
      cond_type cond;
      step_type jump_step;
      step_type next_step;
   } ctrl_type;

   // Control store: on a true condition take jump_step, otherwise next_step
   function automatic ctrl_type microcode(input step_type s);
      ctrl_type w;
      w = '{busy: 1'b0, load: 1'b0, divide: 1'b0, store: 1'b0, set_ptr: 1'b0,
            emit: 1'b0, cond: COND_NEVER, jump_step: STEP_IDLE, next_step: STEP_IDLE};
      unique case (s)
         STEP_IDLE: begin
            w.load      = 1'b1;
            w.cond      = COND_NO_START;
            w.jump_step = STEP_IDLE;
            w.next_step = STEP_DIVIDE;
         end
         STEP_DIVIDE: begin
            w.busy      = 1'b1;
            w.divide    = 1'b1;
            w.cond      = COND_CHUNK_MORE;
            w.jump_step = STEP_DIVIDE;
            w.next_step = STEP_STORE;
         end
         STEP_STORE: begin
            w.busy      = 1'b1;
            w.store     = 1'b1;
            w.cond      = COND_MORE_DIGITS;
            w.jump_step = STEP_DIVIDE;
            w.next_step = STEP_POINT;
         end
         STEP_POINT: begin
            w.busy      = 1'b1;
            w.set_ptr   = 1'b1;
            w.next_step = STEP_EMIT;
         end
         STEP_EMIT: begin
            w.busy      = 1'b1;
            w.emit      = 1'b1;
            w.cond      = COND_PTR_NONZERO;
            w.jump_step = STEP_EMIT;
            w.next_step = STEP_IDLE;
         end
         default: begin
            w.next_step = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

   function automatic logic [CHAR_WIDTH-1:0] digit_to_ascii(input logic [DIGIT_WIDTH-1:0] d);
      logic [CHAR_WIDTH-1:0] c;
      c = CHAR_ZERO + CHAR_WIDTH'(d);
      if (d > DIGIT_NINE) begin
         c = c + ALPHA_GAP;
      end
      return c;
   endfunction

endpackage

/* rtl/i2ra_ram.sv */
module i2ra_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/integer_to_radix_ascii.sv */
// Converts a 31-bit unsigned value to upper-case ASCII digits in radix 2..16
// (radix codes below 2 act as 2, above 16 as 16), most significant digit
// first, one digit per strobe on rsp_valid with rsp_last on the final one;
// zero gives the single digit '0'. Pulse start while busy is low to hand over
// a transaction. A value has at most 31 digits (in radix 2); busy stays high
// from the accepting edge until the final digit: each digit takes four passes
// through the shared divide unit, which resolves eight quotient bits a cycle,
// plus a store step, then one step sets up the read and the digits are emitted
// from the digit RAM. Digits come out in consecutive cycles and cannot be held
// off.
module integer_to_radix_ascii
   import i2ra_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [VALUE_WIDTH-1:0] req_value,
   input  logic [RADIX_WIDTH-1:0] req_radix,
   output logic                   rsp_valid,
   output logic [CHAR_WIDTH-1:0]  rsp_digit_char,
   output logic                   rsp_last
);

   ctrl_type ctrl;
   logic     accept;
   logic     cond_true;

   step_type                step_ff, step_in;
   logic [CHUNK_CNT_W-1:0]  chunk_ff, chunk_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [ADDR_WIDTH-1:0]   ptr_ff, ptr_in;
   logic [DIV_WIDTH-1:0]    dividend_ff, dividend_in;
   logic [DIGIT_WIDTH-1:0]  rem_ff, rem_in;
   logic [RADIX_WIDTH-1:0]  radix_ff, radix_in;
   logic [RADIX_WIDTH-1:0]  radix_clamped;

   logic [RADIX_WIDTH-1:0]  rem_tmp;
   logic [CHUNK_BITS-1:0]   qbits;
   logic [DIGIT_WIDTH-1:0]  rd_digit;

   assign ctrl   = microcode(step_ff);
   assign busy   = ctrl.busy;
   assign accept = start & ~busy;

   always_comb begin
      radix_clamped = req_radix;
      if (req_radix < RADIX_MIN) begin
         radix_clamped = RADIX_MIN;
      end else if (req_radix > RADIX_MAX) begin
         radix_clamped = RADIX_MAX;
      end
   end

   // Eight restoring-division steps on the top byte of the dividend
   always_comb begin
      rem_tmp = RADIX_WIDTH'(rem_ff);
      qbits   = '0;
      for (int i = 0; i < CHUNK_BITS; i++) begin
         rem_tmp = {rem_tmp[DIGIT_WIDTH-1:0], dividend_ff[DIV_WIDTH-1-i]};
         if (rem_tmp >= radix_ff) begin
            rem_tmp                  = rem_tmp - radix_ff;
            qbits[CHUNK_BITS-1-i]    = 1'b1;
         end
      end
   end

   always_comb begin
      unique case (ctrl.cond)
         COND_NEVER:       cond_true = 1'b0;
         COND_NO_START:    cond_true = ~start;
         COND_CHUNK_MORE:  cond_true = (chunk_ff != CHUNK_CNT_W'(CHUNKS - 1));
         COND_MORE_DIGITS: cond_true = (dividend_ff != '0)
                                       && (count_ff != COUNT_WIDTH'(MAX_DIGITS - 1));
         COND_PTR_NONZERO: cond_true = (ptr_ff != '0);
         default:          cond_true = 1'b0;
      endcase
   end

   always_comb begin
      step_in     = cond_true ? ctrl.jump_step : ctrl.next_step;
      chunk_in    = chunk_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      radix_in    = radix_ff;
      if (ctrl.load && accept) begin
         dividend_in = DIV_WIDTH'(req_value);
         radix_in    = radix_clamped;
         rem_in      = '0;
         chunk_in    = '0;
         count_in    = '0;
      end
      if (ctrl.divide) begin
         dividend_in = {dividend_ff[DIV_WIDTH-CHUNK_BITS-1:0], qbits};
         rem_in      = rem_tmp[DIGIT_WIDTH-1:0];
         chunk_in    = chunk_ff + CHUNK_CNT_W'(1);
      end
      if (ctrl.store) begin
         // dividend now holds the quotient; restart the remainder
         rem_in   = '0;
         count_in = count_ff + COUNT_WIDTH'(1);
      end
      if (ctrl.set_ptr) begin
         ptr_in = ADDR_WIDTH'(count_ff - COUNT_WIDTH'(1));
      end
      if (ctrl.emit) begin
         ptr_in = ptr_ff - ADDR_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_IDLE;
         chunk_ff <= '0;
         count_ff <= '0;
         ptr_ff   <= '0;
      end else begin
         step_ff  <= step_in;
         chunk_ff <= chunk_in;
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      radix_ff    <= radix_in;
   end

   // Read address runs one step ahead so the digit is ready in the emit cycle
   i2ra_ram #(
      .WIDTH (DIGIT_WIDTH),
      .DEPTH (MAX_DIGITS)
   ) u_digit_ram (
      .clock   (clock),
      .wr_en   (ctrl.store),
      .wr_addr (count_ff[ADDR_WIDTH-1:0]),
      .wr_data (rem_ff),
      .rd_addr (ptr_in),
      .rd_data (rd_digit)
   );

   assign rsp_valid      = ctrl.emit;
   assign rsp_last       = ctrl.emit & (ptr_ff == '0);
   assign rsp_digit_char = digit_to_ascii(rd_digit);

   a_valid_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("digit strobe outside a transaction");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted transaction did not raise busy");

   a_digits_back_to_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid)
      else $error("gap inside a digit burst");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |=> (!busy && !rsp_valid))
      else $error("block not idle after final digit");

endmodule
